// ===== src/csp_pkg.sv =====
package csp_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       overflow;
  } out_item_t;

  // bucket codes, also the upper address bits of the store
  localparam logic [1:0] CLS_DIGIT  = 2'd0;
  localparam logic [1:0] CLS_LETTER = 2'd1;
  localparam logic [1:0] CLS_OTHER  = 2'd2;

  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_Z = 8'h7a;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_UC_Z = 8'h5a;

  typedef struct packed {
    logic       we;
    logic       re;
    logic [1:0] bucket;
  } mem_ctl_t;

  function automatic logic [1:0] classify(input logic [7:0] c);
    logic [1:0] cls;
    if (c >= CH_0 && c <= CH_9) begin
      cls = CLS_DIGIT;
    end else if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)) begin
      cls = CLS_LETTER;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// ===== src/csp_store.sv =====
module csp_store #(
  parameter int IDX_W = 6
) (
  input  logic              clk,
  input  csp_pkg::mem_ctl_t ctl,
  input  logic [IDX_W-1:0]  idx,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  localparam int DEPTH = 3 * (1 << IDX_W);

  logic [7:0]       mem [0:DEPTH-1];
  logic [IDX_W+1:0] addr;

  assign addr = {ctl.bucket, idx};

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/csp_ctrl.sv =====
module csp_ctrl #(
  parameter int MAX_LEN = 64,
  parameter int IDX_W   = 6,
  parameter int CNT_W   = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  csp_pkg::in_item_t  byte_item,
  output logic               res_valid,
  input  logic               res_stall,
  output csp_pkg::out_item_t res_item,
  output csp_pkg::mem_ctl_t  mem_ctl,
  output logic [IDX_W-1:0]   mem_idx,
  input  logic [7:0]         mem_rdata
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] dcnt, lcnt, ocnt;
  logic [CNT_W-1:0] dcnt_next, lcnt_next, ocnt_next;
  logic             ovf;
  logic [1:0]       rd_bucket;
  logic [IDX_W-1:0] rd_idx;
  logic             last_r;

  logic             in_acc, out_acc, room;
  logic [1:0]       cls;
  logic [CNT_W+1:0] total;
  logic [CNT_W-1:0] cls_cnt, cur_cnt, idx_inc;
  logic             at_end, nb_ok;
  logic [1:0]       nb, start_bucket;

  assign in_acc  = byte_valid && !byte_stall;
  assign out_acc = res_valid && !res_stall;
  assign byte_stall = (state != ST_LOAD);
  assign res_valid  = (state == ST_SHOW);

  assign cls   = csp_pkg::classify(byte_item.in_char);
  assign total = (CNT_W+2)'(dcnt) + (CNT_W+2)'(lcnt) + (CNT_W+2)'(ocnt);
  assign room  = total < (CNT_W+2)'(MAX_LEN);

  always_comb begin
    dcnt_next = dcnt;
    lcnt_next = lcnt;
    ocnt_next = ocnt;
    cls_cnt   = ocnt;
    case (cls)
      csp_pkg::CLS_DIGIT:  cls_cnt = dcnt;
      csp_pkg::CLS_LETTER: cls_cnt = lcnt;
      default:             cls_cnt = ocnt;
    endcase
    if (room) begin
      case (cls)
        csp_pkg::CLS_DIGIT:  dcnt_next = dcnt + 1'b1;
        csp_pkg::CLS_LETTER: lcnt_next = lcnt + 1'b1;
        default:             ocnt_next = ocnt + 1'b1;
      endcase
    end
  end

  // first non-empty bucket once the last byte is in
  always_comb begin
    if (dcnt_next != '0) begin
      start_bucket = csp_pkg::CLS_DIGIT;
    end else if (lcnt_next != '0) begin
      start_bucket = csp_pkg::CLS_LETTER;
    end else begin
      start_bucket = csp_pkg::CLS_OTHER;
    end
  end

  // drain walk: end of current bucket and the next non-empty one
  always_comb begin
    nb_ok = 1'b0;
    nb    = csp_pkg::CLS_OTHER;
    case (rd_bucket)
      csp_pkg::CLS_DIGIT: begin
        cur_cnt = dcnt;
        if (lcnt != '0) begin
          nb_ok = 1'b1;
          nb    = csp_pkg::CLS_LETTER;
        end else if (ocnt != '0) begin
          nb_ok = 1'b1;
          nb    = csp_pkg::CLS_OTHER;
        end
      end
      csp_pkg::CLS_LETTER: begin
        cur_cnt = lcnt;
        if (ocnt != '0) begin
          nb_ok = 1'b1;
          nb    = csp_pkg::CLS_OTHER;
        end
      end
      default: cur_cnt = ocnt;
    endcase
  end

  assign idx_inc = CNT_W'(rd_idx) + 1'b1;
  assign at_end  = (idx_inc == cur_cnt);

  always_comb begin
    mem_ctl.we     = 1'b0;
    mem_ctl.re     = 1'b0;
    mem_ctl.bucket = rd_bucket;
    mem_idx        = rd_idx;
    if (state == ST_LOAD) begin
      mem_ctl.we     = in_acc && room;
      mem_ctl.bucket = cls;
      mem_idx        = IDX_W'(cls_cnt);
    end else if (state == ST_READ) begin
      mem_ctl.re = 1'b1;
    end
  end

  assign res_item.out_char = mem_rdata;
  assign res_item.out_last = last_r;
  assign res_item.overflow = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      dcnt      <= '0;
      lcnt      <= '0;
      ocnt      <= '0;
      ovf       <= 1'b0;
      rd_bucket <= csp_pkg::CLS_DIGIT;
      rd_idx    <= '0;
      last_r    <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            dcnt <= dcnt_next;
            lcnt <= lcnt_next;
            ocnt <= ocnt_next;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (byte_item.in_last) begin
              rd_bucket <= start_bucket;
              rd_idx    <= '0;
              state     <= ST_READ;
            end
          end
        end
        ST_READ: begin
          // address already issued; step to the following entry
          last_r <= at_end && !nb_ok;
          if (at_end) begin
            rd_bucket <= nb;
            rd_idx    <= '0;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
          state <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_acc) begin
            if (last_r) begin
              dcnt      <= '0;
              lcnt      <= '0;
              ocnt      <= '0;
              ovf       <= 1'b0;
              rd_bucket <= csp_pkg::CLS_DIGIT;
              rd_idx    <= '0;
              state     <= ST_LOAD;
            end else begin
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

// ===== src/char_class_stable_partition_top.sv =====
// channel | dir | handshake               | payload
// byte    | in  | byte_valid / byte_stall  | csp_pkg::in_item_t  (in_char, in_last)
// res     | out | res_valid  / res_stall   | csp_pkg::out_item_t (out_char, out_last, overflow)
//
// Loading takes one item per cycle; each byte that fits goes into a single store RAM.
// The item marked last starts a drain: every result takes a read state of the RAM
// and then a show state, where it waits until it is taken with res_stall low.
// Inputs are stalled for the whole drain, also while res_stall is held high.
// rst is synchronous and clears counts, overflow and state; the RAM needs no clearing.
// A stalled result holds in the RAM read register until taken.
module char_class_stable_partition_top #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  csp_pkg::in_item_t  byte_item,
  output logic               res_valid,
  input  logic               res_stall,
  output csp_pkg::out_item_t res_item
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  csp_pkg::mem_ctl_t mem_ctl;
  logic [IDX_W-1:0]  mem_idx;
  logic [7:0]        mem_rdata;

  csp_ctrl #(
    .MAX_LEN(MAX_LEN),
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .mem_ctl   (mem_ctl),
    .mem_idx   (mem_idx),
    .mem_rdata (mem_rdata)
  );

  csp_store #(
    .IDX_W(IDX_W)
  ) u_store (
    .clk  (clk),
    .ctl  (mem_ctl),
    .idx  (mem_idx),
    .wdata(byte_item.in_char),
    .rdata(mem_rdata)
  );

  // no byte is taken while a result is on offer
  a_no_load_in_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> byte_stall)
    else $error("byte input open during drain");

  // after the final result goes out, the output goes quiet and the input reopens
  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && res_item.out_last |=> !res_valid && !byte_stall)
    else $error("drain did not end after last item");

  // input reopens only after the final result was taken
  a_reopen_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(byte_stall) && !$past(rst) |->
      $past(res_valid && !res_stall && res_item.out_last))
    else $error("input reopened before drain finished");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CAP         = 64;
  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 20;
  localparam int PHASE_ITEMS = 45;
  localparam int N_DIR       = 19;

  typedef struct packed {
    logic [7:0]         ch;
    logic               last;
    logic               typed;
    csp_pkg::out_item_t res;
  } row_t;

  // single-byte strings carry their result inline; the mixed string goes through the predictor
  localparam row_t DIR_TAB [N_DIR] = '{
    '{8'h00,            1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{8'hff,            1'b1, 1'b1, '{8'hff, 1'b1, 1'b0}},
    '{csp_pkg::CH_0,    1'b1, 1'b1, '{8'h30, 1'b1, 1'b0}},
    '{csp_pkg::CH_UC_Z, 1'b1, 1'b1, '{8'h5a, 1'b1, 1'b0}},
    '{8'h2f,            1'b0, 1'b0, '0},
    '{csp_pkg::CH_LC_A, 1'b0, 1'b0, '0},
    '{8'h3a,            1'b0, 1'b0, '0},
    '{csp_pkg::CH_9,    1'b0, 1'b0, '0},
    '{8'h40,            1'b0, 1'b0, '0},
    '{csp_pkg::CH_UC_Z, 1'b0, 1'b0, '0},
    '{8'h5b,            1'b0, 1'b0, '0},
    '{csp_pkg::CH_0,    1'b0, 1'b0, '0},
    '{8'h60,            1'b0, 1'b0, '0},
    '{csp_pkg::CH_UC_A, 1'b0, 1'b0, '0},
    '{8'h7b,            1'b0, 1'b0, '0},
    '{csp_pkg::CH_LC_Z, 1'b0, 1'b0, '0},
    '{8'h7f,            1'b0, 1'b0, '0},
    '{8'h80,            1'b0, 1'b0, '0},
    '{8'h55,            1'b1, 1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               byte_valid;
  logic               byte_stall;
  csp_pkg::in_item_t  byte_item;
  logic               res_valid;
  logic               res_stall;
  csp_pkg::out_item_t res_item;

  // predictor state
  logic [7:0]         digit_bucket[$];
  logic [7:0]         alpha_bucket[$];
  logic [7:0]         misc_bucket[$];
  logic               str_dropped;
  csp_pkg::out_item_t step_res[$];
  csp_pkg::out_item_t reorder_q[$];

  int src_pct;
  int sink_pct;
  int hold_seq;
  int hold_seen;
  int hold_left;
  int err_cnt;
  int sent_cnt;
  int n_checked;
  int n_strings;
  int n_ovf_str;
  int cyc;

  char_class_stable_partition_top #(.MAX_LEN(CAP)) uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] byte_class(input logic [7:0] c);
    if (c inside {[csp_pkg::CH_0:csp_pkg::CH_9]}) return csp_pkg::CLS_DIGIT;
    if (c inside {[csp_pkg::CH_UC_A:csp_pkg::CH_UC_Z], [csp_pkg::CH_LC_A:csp_pkg::CH_LC_Z]})
      return csp_pkg::CLS_LETTER;
    return csp_pkg::CLS_OTHER;
  endfunction

  // one accepted byte; fills step_res with the results it releases
  function automatic void partition_step(input csp_pkg::in_item_t it);
    int kept;
    csp_pkg::out_item_t r;
    kept = digit_bucket.size() + alpha_bucket.size() + misc_bucket.size();
    step_res.delete();
    if (kept >= CAP) begin
      str_dropped = 1'b1;
    end else begin
      case (byte_class(it.in_char))
        csp_pkg::CLS_DIGIT:  digit_bucket.push_back(it.in_char);
        csp_pkg::CLS_LETTER: alpha_bucket.push_back(it.in_char);
        default:             misc_bucket.push_back(it.in_char);
      endcase
    end
    if (it.in_last) begin
      r.out_last = 1'b0;
      r.overflow = str_dropped;
      foreach (digit_bucket[i]) begin
        r.out_char = digit_bucket[i];
        step_res.push_back(r);
      end
      foreach (alpha_bucket[i]) begin
        r.out_char = alpha_bucket[i];
        step_res.push_back(r);
      end
      foreach (misc_bucket[i]) begin
        r.out_char = misc_bucket[i];
        step_res.push_back(r);
      end
      r = step_res[step_res.size() - 1];
      r.out_last = 1'b1;
      step_res[step_res.size() - 1] = r;
      n_strings++;
      if (str_dropped) n_ovf_str++;
      digit_bucket.delete();
      alpha_bucket.delete();
      misc_bucket.delete();
      str_dropped = 1'b0;
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(3))
      0:       return csp_pkg::CH_0 + 8'($urandom_range(9));
      1:       return csp_pkg::CH_UC_A + 8'($urandom_range(25));
      2:       return csp_pkg::CH_LC_A + 8'($urandom_range(25));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly short strings, a few around the capacity edge
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(10, 1);
    if (r < 95) return $urandom_range(40, 11);
    return $urandom_range(CAP + 4, CAP - 2);
  endfunction

  task automatic send_byte(input csp_pkg::in_item_t it, input logic typed,
                           input csp_pkg::out_item_t typed_res);
    while ($urandom_range(99) < src_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_item  <= it;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sent_cnt++;
    partition_step(it);
    if (typed) begin
      reorder_q.push_back(typed_res);
    end else begin
      foreach (step_res[i]) reorder_q.push_back(step_res[i]);
    end
  endtask

  task automatic send_string(input int len);
    csp_pkg::in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.in_char = rand_byte();
      it.in_last = (i == len - 1);
      send_byte(it, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    while (reorder_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result checker and stall generator
  always @(posedge clk) begin
    csp_pkg::out_item_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (reorder_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item, expected none, got %h", $time, res_item);
        end else begin
          want = reorder_q.pop_front();
          n_checked++;
          if (res_item.out_char !== want.out_char) begin
            err_cnt++;
            $display("%0t: out_char mismatch, expected %h, got %h",
                     $time, want.out_char, res_item.out_char);
          end
          if (res_item.out_last !== want.out_last) begin
            err_cnt++;
            $display("%0t: out_last mismatch, expected %b, got %b",
                     $time, want.out_last, res_item.out_last);
          end
          if (res_item.overflow !== want.overflow) begin
            err_cnt++;
            $display("%0t: overflow mismatch, expected %b, got %b",
                     $time, want.overflow, res_item.overflow);
          end
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < sink_pct);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, reorder_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int base;
    csp_pkg::in_item_t it;
    clk         = 1'b0;
    rst         = 1'b1;
    byte_valid  = 1'b0;
    byte_item   = '0;
    res_stall   = 1'b0;
    str_dropped = 1'b0;
    src_pct     = 0;
    sink_pct    = 0;
    hold_seq    = 0;
    hold_seen   = 0;
    hold_left   = 0;
    err_cnt     = 0;
    sent_cnt    = 0;
    n_checked   = 0;
    n_strings   = 0;
    n_ovf_str   = 0;
    cyc         = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      it.in_char = DIR_TAB[i].ch;
      it.in_last = DIR_TAB[i].last;
      send_byte(it, DIR_TAB[i].typed, DIR_TAB[i].res);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_pct = 0;  sink_pct = 0;  end
        1: begin src_pct = 51; sink_pct = 0;  end
        2: begin src_pct = 0;  sink_pct = 51; end
        default: begin src_pct = 15; sink_pct = 15; end
      endcase
      base = sent_cnt;
      while (sent_cnt - base < PHASE_ITEMS) send_string(pick_len());
      wait_drained();

      if (ph == 1) begin
        // long sink hold while a full string and an overfull one keep coming
        src_pct  = 0;
        sink_pct = 0;
        hold_seq++;
        send_string(CAP);
        send_string(CAP + 1);
        wait_drained();
      end
    end

    if (reorder_q.size() != 0) begin
      err_cnt += reorder_q.size();
      $display("%0t: %0d expected items never arrived", $time, reorder_q.size());
    end
    $display("Run covered %0d bytes in %0d strings, %0d with dropped bytes;", sent_cnt,
             n_strings, n_ovf_str);
    $display("%0d reordered bytes checked across four idle/stall mixes and a long sink hold",
             n_checked);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
